// ===== rtl/core/fcdn_pkg.sv =====
// Shared types and constants of the FAST corner detector with suppression.
// Used by fast_corner_detect_nms; depends on nothing else.
package fcdn_pkg;

	localparam int CIRCLE_POINTS  = 16;
	localparam int MAX_NMS_RADIUS = 3;
	localparam int WIN            = 2 * MAX_NMS_RADIUS + 1;
	localparam int LINE_ROWS      = 6;
	localparam int PIX_W          = 8;
	localparam int SCORE_W        = 12;
	localparam int ROW_W          = 13;
	localparam int ROW_CAP        = 8191;
	localparam int MIN_DIM        = 7;
	localparam int MAX_HEIGHT     = 4096;

	typedef logic [PIX_W-1:0]   pixel_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic signed [15:0] coord_t;

	localparam logic [2:0] CFG_THRESHOLD    = 3'd0;
	localparam logic [2:0] CFG_ARC_LENGTH   = 3'd1;
	localparam logic [2:0] CFG_NMS_RADIUS   = 3'd2;
	localparam logic [2:0] CFG_MAX_FEATURES = 3'd3;
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;

	localparam logic [7:0]  RST_THRESHOLD    = 8'd50;
	localparam logic [4:0]  RST_ARC_LENGTH   = 5'd9;
	localparam logic [1:0]  RST_NMS_RADIUS   = 2'd1;
	localparam logic [15:0] RST_MAX_FEATURES = 16'd3000;
	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1241;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd376;

	// Bresenham circle of radius 3, clockwise from the top
	localparam int RING_DX [CIRCLE_POINTS] =
		'{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
	localparam int RING_DY [CIRCLE_POINTS] =
		'{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
	localparam int COMPASS [4] = '{0, 4, 8, 12};

endpackage

// ===== rtl/core/fast_corner_detect_nms.sv =====
// FAST-16 corner detector with non-maximum suppression, top level.
// Depends on fcdn_pkg (types, circle tables, register indexes).
//
// Usage:
// - s_axis carries one grayscale pixel per transaction in raster order;
//   tuser[0] marks pixel (0,0) of a new frame and clears the counters.
// - m_axis carries one keypoint per transaction in raster order.
// - cfg_we/cfg_index/cfg_data write threshold, arc_length, nms_radius,
//   max_features, image_width and image_height (indexes 0 to 5).
// Throughput: one pixel per cycle while s_axis_tready is high. Pixel rows live in a line memory and
// score rows in a second one, each read one column ahead and written back
// once per pixel; a five-stage pipeline scores and suppresses.
// Latency: a keypoint at (y,x) leaves through the pipeline registers
// (r+3)*width + (r+3) pixels after its own pixel, r = nms_radius. After a
// frame, feed that many extra pixels without frame_start to flush the last keypoints.
// Reset: counters and pipeline valid flags clear, configuration registers load their defaults;
// line memories are not cleared and need six rows of the new frame before they are used.
// Stall: s_axis_tready drops only while a keypoint waits behind an
// untaken result; pixels that produce nothing keep flowing.
module fast_corner_detect_nms #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
	input  logic [0:0]  s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [10:0] key_x, [22:11] key_y, [34:23] corner_score
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = CW + 1;
	localparam int PWORD = fcdn_pkg::LINE_ROWS * fcdn_pkg::PIX_W;
	localparam int SWORD = fcdn_pkg::LINE_ROWS * fcdn_pkg::SCORE_W;
	localparam int WN    = fcdn_pkg::WIN;
	localparam int PW    = fcdn_pkg::PIX_W;
	localparam int SW    = fcdn_pkg::SCORE_W;

	// configuration
	logic [7:0]  thr_q;
	logic [4:0]  arc_q;
	logic [1:0]  rad_q;
	logic [15:0] maxf_q;
	logic [11:0] iw_q;
	logic [12:0] ih_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= fcdn_pkg::RST_THRESHOLD;
			arc_q  <= fcdn_pkg::RST_ARC_LENGTH;
			rad_q  <= fcdn_pkg::RST_NMS_RADIUS;
			maxf_q <= fcdn_pkg::RST_MAX_FEATURES;
			iw_q   <= fcdn_pkg::RST_IMAGE_WIDTH;
			ih_q   <= fcdn_pkg::RST_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				fcdn_pkg::CFG_THRESHOLD:    thr_q  <= cfg_data[7:0];
				fcdn_pkg::CFG_ARC_LENGTH:   arc_q  <= cfg_data[4:0];
				fcdn_pkg::CFG_NMS_RADIUS:   rad_q  <= cfg_data[1:0];
				fcdn_pkg::CFG_MAX_FEATURES: maxf_q <= cfg_data;
				fcdn_pkg::CFG_IMAGE_WIDTH:  iw_q   <= cfg_data[11:0];
				fcdn_pkg::CFG_IMAGE_HEIGHT: ih_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]  ew;
	logic [12:0]    eh;
	logic [1:0]     rad;
	logic [4:0]     arcn;

	always_comb begin
		if (iw_q < 12'(fcdn_pkg::MIN_DIM))
			ew = WW'(fcdn_pkg::MIN_DIM);
		else if (32'(iw_q) > MAX_WIDTH)
			ew = WW'(MAX_WIDTH);
		else
			ew = WW'(iw_q);
		if (ih_q < 13'(fcdn_pkg::MIN_DIM))
			eh = 13'(fcdn_pkg::MIN_DIM);
		else if (ih_q > 13'(fcdn_pkg::MAX_HEIGHT))
			eh = 13'(fcdn_pkg::MAX_HEIGHT);
		else
			eh = ih_q;
		rad  = (32'(rad_q) > fcdn_pkg::MAX_NMS_RADIUS) ?
			2'(fcdn_pkg::MAX_NMS_RADIUS) : rad_q;
		arcn = (arc_q > 5'(fcdn_pkg::CIRCLE_POINTS)) ?
			5'(fcdn_pkg::CIRCLE_POINTS) : arc_q;
	end

	function automatic logic in_frame(fcdn_pkg::coord_t y, fcdn_pkg::coord_t x,
		fcdn_pkg::coord_t w, fcdn_pkg::coord_t h);
		return (y >= 16'sd3) && (x >= 16'sd3) && (y <= h - 16'sd4) && (x <= w - 16'sd4);
	endfunction

	// pipeline control
	logic en;
	logic accept;
	logic emit_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic out_v_q;

	assign en            = !(out_v_q && !m_axis_tready && emit_s4);
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// position counters
	logic [CW-1:0] col_q;
	logic [12:0]   row_q;
	logic [CW-1:0] c_in;
	logic [12:0]   r_in;
	logic [CW-1:0] col_next;
	logic [12:0]   row_next;
	logic          col_wrap;
	logic          int_in;
	logic          cok_in;
	fcdn_pkg::coord_t wc, hc, cyc, cxc, dd;

	always_comb begin
		c_in     = s_axis_tuser[0] ? '0 : col_q;
		r_in     = s_axis_tuser[0] ? '0 : row_q;
		col_wrap = (WW'(c_in) + WW'(1)) >= ew;
		col_next = col_wrap ? '0 : c_in + CW'(1);
		if (col_wrap && r_in != 13'(fcdn_pkg::ROW_CAP))
			row_next = r_in + 13'd1;
		else
			row_next = r_in;
		wc     = fcdn_pkg::coord_t'(ew);
		hc     = fcdn_pkg::coord_t'(eh);
		int_in = in_frame(fcdn_pkg::coord_t'(r_in) - 16'sd3,
			fcdn_pkg::coord_t'(c_in) - 16'sd3, wc, hc);
		dd  = fcdn_pkg::coord_t'(rad) + 16'sd3;
		cyc = fcdn_pkg::coord_t'(r_in) - dd;
		cxc = fcdn_pkg::coord_t'(c_in) - dd;
		if (cxc < 16'sd0) begin
			cxc = cxc + wc;
			cyc = cyc - 16'sd1;
		end
		cok_in = in_frame(cyc, cxc, wc, hc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// pixel line memory: six earlier rows per column, read one column ahead
	logic [PWORD-1:0] pmem [MAX_WIDTH];
	logic [PWORD-1:0] prd_q;
	logic [CW-1:0]    p_raddr;

	assign p_raddr = accept ? col_next : col_q;

	always_ff @(posedge clk) begin
		if (accept)
			pmem[c_in] <= {prd_q[PWORD-PW-1:0], s_axis_tdata};
		prd_q <= pmem[p_raddr];
	end

	// 7x7 pixel window, column 0 newest, row 0 newest
	fcdn_pkg::pixel_t pw [WN][WN];

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = WN - 1; k > 0; k--)
				pw[k] <= pw[k-1];
			pw[0][0] <= s_axis_tdata;
			for (int j = 1; j < WN; j++)
				pw[0][j] <= prd_q[(j-1)*PW +: PW];
		end
	end

	// stage payloads
	logic            int_s1, int_s2;
	logic            cok_s1, cok_s2, cok_s3, cok_s4;
	logic            fs_s1, fs_s2, fs_s3, fs_s4;
	logic [11:0]     cy_s1, cy_s2, cy_s3, cy_s4;
	logic [10:0]     cx_s1, cx_s2, cx_s3, cx_s4;
	logic [CW-1:0]   c_s1, c_s2, c_s3;
	logic [15:0]     br_s2, dk_s2;
	logic [9:0]      g_s2 [4];
	fcdn_pkg::score_t score_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: classify circle pixels, absolute differences in groups of four
	logic [15:0] br_c, dk_c;
	logic [9:0]  g_c [4];

	always_comb begin
		fcdn_pkg::pixel_t p, v, a;
		p = pw[3][3];
		for (int q = 0; q < 4; q++)
			g_c[q] = '0;
		for (int i = 0; i < fcdn_pkg::CIRCLE_POINTS; i++) begin
			v = pw[3 - fcdn_pkg::RING_DX[i]][3 - fcdn_pkg::RING_DY[i]];
			br_c[i] = {1'b0, v} >= ({1'b0, p} + {1'b0, thr_q});
			dk_c[i] = ({1'b0, v} + {1'b0, thr_q}) <= {1'b0, p};
			a = (v > p) ? v - p : p - v;
			g_c[i/4] = g_c[i/4] + 10'(a);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			int_s1 <= int_in;
			cok_s1 <= cok_in;
			fs_s1  <= s_axis_tuser[0];
			cy_s1  <= cyc[11:0];
			cx_s1  <= cxc[10:0];
			c_s1   <= c_in;

			int_s2 <= int_s1;
			cok_s2 <= cok_s1;
			fs_s2  <= fs_s1;
			cy_s2  <= cy_s1;
			cx_s2  <= cx_s1;
			c_s2   <= c_s1;
			br_s2  <= br_c;
			dk_s2  <= dk_c;
			g_s2   <= g_c;
		end
	end

	// stage 2: compass test, contiguous arc, score sum
	fcdn_pkg::score_t score_c;

	always_comb begin
		logic [2:0]  nb, nd;
		logic [15:0] mask, rb, rd;
		logic        hit;
		nb = '0;
		nd = '0;
		for (int i = 0; i < 4; i++) begin
			nb = nb + 3'(br_s2[fcdn_pkg::COMPASS[i]]);
			nd = nd + 3'(!br_s2[fcdn_pkg::COMPASS[i]] && dk_s2[fcdn_pkg::COMPASS[i]]);
		end
		if (arcn >= 5'(fcdn_pkg::CIRCLE_POINTS))
			mask = '1;
		else
			mask = 16'((17'd1 << arcn) - 17'd1);
		hit = 1'b0;
		for (int i = 0; i < fcdn_pkg::CIRCLE_POINTS; i++) begin
			rb  = (br_s2 >> i) | (br_s2 << (fcdn_pkg::CIRCLE_POINTS - i));
			rd  = (dk_s2 >> i) | (dk_s2 << (fcdn_pkg::CIRCLE_POINTS - i));
			hit = hit || (&(rb | ~mask)) || (&(rd | ~mask));
		end
		if (int_s2 && (nb >= 3'd3 || nd >= 3'd3) && hit)
			score_c = SW'(g_s2[0]) + SW'(g_s2[1]) + SW'(g_s2[2]) + SW'(g_s2[3]);
		else
			score_c = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cok_s3   <= cok_s2;
			fs_s3    <= fs_s2;
			cy_s3    <= cy_s2;
			cx_s3    <= cx_s2;
			c_s3     <= c_s2;
			score_s3 <= score_c;
		end
	end

	// score line memory: six earlier score rows per column
	logic [SWORD-1:0] smem [MAX_WIDTH];
	logic [SWORD-1:0] srd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			srd_q <= smem[c_s2];
			if (v_s3)
				smem[c_s3] <= {srd_q[SWORD-SW-1:0], score_s3};
		end
	end

	// stage 3: shift the 7x7 score window
	fcdn_pkg::score_t sw [WN][WN];

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			for (int k = WN - 1; k > 0; k--)
				sw[k] <= sw[k-1];
			sw[0][0] <= score_s3;
			for (int j = 1; j < WN; j++)
				sw[0][j] <= srd_q[(j-1)*SW +: SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cok_s4 <= cok_s3;
			fs_s4  <= fs_s3;
			cy_s4  <= cy_s3;
			cx_s4  <= cx_s3;
		end
	end

	// stage 4: window maximum and feature limit
	fcdn_pkg::score_t center;
	logic             keep;
	logic [15:0]      cnt_eff;
	logic [15:0]      fcount_q;

	always_comb begin
		center = cok_s4 ? sw[{1'b0, rad}][{1'b0, rad}] : '0;
		keep   = 1'b1;
		for (int k = 0; k < WN; k++)
			for (int j = 0; j < WN; j++)
				if (k <= 2 * int'(rad) && j <= 2 * int'(rad) && sw[k][j] > center)
					keep = 1'b0;
		cnt_eff = fs_s4 ? '0 : fcount_q;
		emit_s4 = v_s4 && (center != '0) && (cnt_eff < maxf_q) && keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fcount_q <= '0;
		else if (en && v_s4)
			fcount_q <= cnt_eff + 16'(emit_s4);
	end

	// output register
	logic [10:0]      okx_q;
	logic [11:0]      oky_q;
	fcdn_pkg::score_t osc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en && emit_s4)
			out_v_q <= 1'b1;
		else if (m_axis_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en && emit_s4) begin
			okx_q <= cx_s4;
			oky_q <= cy_s4;
			osc_q <= center;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'b0, osc_q, oky_q, okx_q};

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked keypoint");
	a_score_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[34:23] != 12'd0))
		else $error("keypoint with zero score");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit_s4) |=> (fcount_q == $past(cnt_eff) + 16'd1))
		else $error("feature count did not advance on a keypoint");
	a_emit_center: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit_s4) |=> (m_axis_tvalid && $past(cok_s4)))
		else $error("keypoint emitted from a center outside the frame");
`endif

endmodule
